// ===== rtl/fthi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fthi_pkg;

  // Field widths
  localparam int ID_W   = 32;
  localparam int HASH_W = 32;
  localparam int SLOT_W = 10;

  // Default number of table slots
  localparam int TABLE_ENTRIES_DEF = 1000;

endpackage

`default_nettype wire

// ===== rtl/flow_triple_hash_index_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+----------------------------
// input     | start, busy, in_flow_id                       | start && !busy
// result    | out_valid, out_slot_first/second/third        | one-cycle strobe, no stall
//
// An accepted transaction reaches its out_valid strobe through the input
// register, four mix stages and three modulo stages.
// One transaction per cycle; busy is low whenever rst_n is high, since every
// stage advances each cycle. Reset (rst_n, synchronous) clears only the valid
// pipeline and holds busy high so nothing is taken in while it is asserted.
// The receiver cannot stall, so no result is ever held back.
module flow_triple_hash_index_core #(
  parameter int TABLE_ENTRIES = fthi_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [fthi_pkg::ID_W-1:0]   in_flow_id,
  output logic                                    out_valid,
  output logic             [fthi_pkg::SLOT_W-1:0] out_slot_first,
  output logic             [fthi_pkg::SLOT_W-1:0] out_slot_second,
  output logic             [fthi_pkg::SLOT_W-1:0] out_slot_third
);
  import fthi_pkg::*;

  localparam int LAT = 8;
  localparam int RW  = $clog2(TABLE_ENTRIES) + 1;

  logic              accept;
  logic [ID_W-1:0]   id_r;
  logic [LAT-1:0]    vld_r, vld_nxt;
  logic [HASH_W-1:0] h1, h2, h3;
  logic [RW-1:0]     r1, r2, r3;

  // Fully pipelined; only reset holds the input off.
  assign busy   = !rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      id_r <= in_flow_id;
    end
  end

  // Transaction marker follows the data down the pipe.
  assign vld_nxt = {vld_r[LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  fthi_mix u_mix (
    .clk         (clk),
    .id          (id_r),
    .hash_first  (h1),
    .hash_second (h2),
    .hash_third  (h3)
  );

  fthi_modred #(.N(TABLE_ENTRIES)) u_mod_first (
    .clk (clk),
    .x   (h1),
    .rem (r1)
  );

  fthi_modred #(.N(TABLE_ENTRIES)) u_mod_second (
    .clk (clk),
    .x   (h2),
    .rem (r2)
  );

  fthi_modred #(.N(TABLE_ENTRIES)) u_mod_third (
    .clk (clk),
    .x   (h3),
    .rem (r3)
  );

  // Wide tables keep only the low slot bits of the remainder.
  assign out_valid       = vld_r[LAT-1];
  assign out_slot_first  = SLOT_W'(HASH_W'(r1));
  assign out_slot_second = SLOT_W'(HASH_W'(r2));
  assign out_slot_third  = SLOT_W'(HASH_W'(r3));

  // Every accepted transaction produces exactly one strobe.
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##8 out_valid)
    else $error("result strobe missing after accepted transaction");

  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 8))
    else $error("result strobe without an accepted transaction");

  a_first_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (TABLE_ENTRIES > 1024) || (HASH_W'(out_slot_first) < TABLE_ENTRIES))
    else $error("first slot out of table range");

  a_third_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (TABLE_ENTRIES > 1024) ||
      ((HASH_W'(out_slot_second) < TABLE_ENTRIES) &&
       (HASH_W'(out_slot_third) < TABLE_ENTRIES)))
    else $error("second or third slot out of table range");

endmodule

`default_nettype wire

// ===== rtl/fthi_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Four-stage integer mix: 64-to-32 mix and 32-bit mix side by side,
// plus the combined hash in the last stage.
module fthi_mix (
  input  wire logic                        clk,
  input  wire logic [fthi_pkg::ID_W-1:0]   id,
  output logic      [fthi_pkg::HASH_W-1:0] hash_first,
  output logic      [fthi_pkg::HASH_W-1:0] hash_second,
  output logic      [fthi_pkg::HASH_W-1:0] hash_third
);
  import fthi_pkg::*;

  localparam int W64 = 2 * HASH_W;

  // stage 1
  logic [W64-1:0]    k0, a1, sh1, w1_nxt, w1_r;
  logic [HASH_W-1:0] a2, sh2, v1_nxt, v1_r;
  // stage 2
  logic [W64-1:0]    m2_nxt, m2_r;
  logic [HASH_W-1:0] c2, sh3, v2_nxt, v2_r;
  // stage 3
  logic [W64-1:0]    e3, sh4, f3_nxt, f3_r;
  logic [HASH_W-1:0] g3, sh5, v3_nxt, v3_r;
  // stage 4
  logic [W64-1:0]    sh6;
  logic [HASH_W-1:0] h1_nxt, h1_r, h2_r, h3_nxt, h3_r;

  always_comb begin
    k0     = {{(W64-ID_W){id[ID_W-1]}}, id};
    a1     = ~k0 + (k0 << 18);
    sh1    = W64'($signed(a1) >>> 31);
    w1_nxt = a1 ^ sh1;

    a2     = id + ~(id << 15);
    sh2    = HASH_W'($signed(a2) >>> 10);
    v1_nxt = a2 ^ sh2;
  end

  always_comb begin
    // times 21 as shift-add
    m2_nxt = (w1_r << 4) + (w1_r << 2) + w1_r;

    c2     = v1_r + (v1_r << 3);
    sh3    = HASH_W'($signed(c2) >>> 6);
    v2_nxt = c2 ^ sh3;
  end

  always_comb begin
    sh4    = W64'($signed(m2_r) >>> 11);
    e3     = m2_r ^ sh4;
    f3_nxt = e3 + (e3 << 6);

    g3     = v2_r + ~(v2_r << 11);
    sh5    = HASH_W'($signed(g3) >>> 16);
    v3_nxt = g3 ^ sh5;
  end

  always_comb begin
    sh6    = W64'($signed(f3_r) >>> 22);
    h1_nxt = f3_r[HASH_W-1:0] ^ sh6[HASH_W-1:0];
    h3_nxt = h1_nxt ^ (v3_r << 1);
  end

  always_ff @(posedge clk) begin
    w1_r <= w1_nxt;
    v1_r <= v1_nxt;
    m2_r <= m2_nxt;
    v2_r <= v2_nxt;
    f3_r <= f3_nxt;
    v3_r <= v3_nxt;
    h1_r <= h1_nxt;
    h2_r <= v3_r;
    h3_r <= h3_nxt;
  end

  assign hash_first  = h1_r;
  assign hash_second = h2_r;
  assign hash_third  = h3_r;

endmodule

`default_nettype wire

// ===== rtl/fthi_modred.sv =====
`timescale 1ns / 1ps
`default_nettype none

// x mod N in three stages: reciprocal multiply, back-multiply, subtract
// with one correction. The quotient estimate is exact or one low.
module fthi_modred #(
  parameter int N = fthi_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic [fthi_pkg::HASH_W-1:0]   x,
  output logic      [$clog2(N):0]            rem
);
  import fthi_pkg::*;

  localparam int RW = $clog2(N) + 1;
  localparam logic [HASH_W-1:0]   RECIP = HASH_W'((64'd1 << HASH_W) / N);
  localparam logic [HASH_W-1:0]   NDIV  = HASH_W'(N);
  localparam logic [RW-1:0]       NREM  = RW'(N);

  logic [2*HASH_W-1:0] prod_nxt;
  logic [HASH_W-1:0]   q_r, xa_r, xb_r, qn_nxt, qn_r, diff;
  logic [RW-1:0]       diff_lo, rem_nxt, rem_r;

  always_comb begin
    prod_nxt = (2*HASH_W)'(x) * (2*HASH_W)'(RECIP);
    qn_nxt   = q_r * NDIV;
    diff     = xb_r - qn_r;
    diff_lo  = diff[RW-1:0];
    rem_nxt  = (diff_lo >= NREM) ? (diff_lo - NREM) : diff_lo;
  end

  always_ff @(posedge clk) begin
    q_r   <= prod_nxt[2*HASH_W-1:HASH_W];
    xa_r  <= x;
    qn_r  <= qn_nxt;
    xb_r  <= xa_r;
    rem_r <= rem_nxt;
  end

  assign rem = rem_r;

endmodule

`default_nettype wire

// ===== verif/flow_triple_hash_index_checker.sv =====
`timescale 1ns / 1ps

// Watches the input and result channels, predicts three slots per accepted
// transaction and checks every result strobe against the oldest prediction.
module flow_triple_hash_index_checker #(
  parameter int TABLE_ENTRIES = fthi_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic signed [fthi_pkg::ID_W-1:0]      flow_id,
  input  logic                                  out_valid,
  input  logic        [fthi_pkg::SLOT_W-1:0]    slot_first,
  input  logic        [fthi_pkg::SLOT_W-1:0]    slot_second,
  input  logic        [fthi_pkg::SLOT_W-1:0]    slot_third,
  output int                                    mismatches,
  output int                                    slots_pending,
  output int                                    results_checked
);
  import fthi_pkg::*;

  localparam logic [HASH_W-1:0] ENTRIES_U = TABLE_ENTRIES;

  typedef struct packed {
    logic [ID_W-1:0]   flow_id;
    logic [SLOT_W-1:0] first;
    logic [SLOT_W-1:0] second;
    logic [SLOT_W-1:0] third;
  } slot_set_t;

  slot_set_t slots_due[$];

  initial begin
    mismatches      = 0;
    slots_pending   = 0;
    results_checked = 0;
  end

  // 64-bit mix on the sign-extended id, folded to the low 32 bits.
  function automatic logic [HASH_W-1:0] mix_wide_id(input logic [ID_W-1:0] id);
    logic signed [63:0] k;
    k = {{32{id[ID_W-1]}}, id};
    k = ~k + (k << 18);
    k = k ^ (k >>> 31);
    k = k * 64'sd21;
    k = k ^ (k >>> 11);
    k = k + (k << 6);
    k = k ^ (k >>> 22);
    return k[HASH_W-1:0];
  endfunction

  function automatic logic [HASH_W-1:0] mix_narrow_id(input logic [ID_W-1:0] id);
    logic signed [31:0] k;
    k = id;
    k = k + ~(k << 15);
    k = k ^ (k >>> 10);
    k = k + (k << 3);
    k = k ^ (k >>> 6);
    k = k + ~(k << 11);
    k = k ^ (k >>> 16);
    return k;
  endfunction

  // Remainder wider than the port (table above 1024) keeps its low bits.
  function automatic logic [SLOT_W-1:0] hash_to_slot(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] r;
    r = h % ENTRIES_U;
    return r[SLOT_W-1:0];
  endfunction

  function automatic slot_set_t predict_slots(input logic [ID_W-1:0] id);
    slot_set_t s;
    logic [HASH_W-1:0] h1, h2, h3;
    h1 = mix_wide_id(id);
    h2 = mix_narrow_id(id);
    h3 = h1 ^ (h2 << 1);
    s.flow_id = id;
    s.first   = hash_to_slot(h1);
    s.second  = hash_to_slot(h2);
    s.third   = hash_to_slot(h3);
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR t=%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    slot_set_t due;
    if (rst_n) begin
      if (out_valid) begin
        if (slots_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: %0d %0d %0d",
                                    slot_first, slot_second, slot_third));
        end else begin
          due = slots_due.pop_front();
          results_checked++;
          if (slot_first !== due.first)
            report_mismatch($sformatf("flow_id %h slot_first %0d, want %0d",
                                      due.flow_id, slot_first, due.first));
          if (slot_second !== due.second)
            report_mismatch($sformatf("flow_id %h slot_second %0d, want %0d",
                                      due.flow_id, slot_second, due.second));
          if (slot_third !== due.third)
            report_mismatch($sformatf("flow_id %h slot_third %0d, want %0d",
                                      due.flow_id, slot_third, due.third));
        end
      end
      if (start && !busy) begin
        slots_due.insert(slots_due.size(), predict_slots(flow_id));
      end
      slots_pending = slots_due.size();
    end
  end

endmodule

// ===== verif/flow_triple_hash_index_core_tb.sv =====
`timescale 1ns / 1ps

// Top of the bench: clock, reset, stimulus and verdict. All prediction and
// comparison lives in the checker instance beside the DUT.
module flow_triple_hash_index_core_tb;
  import fthi_pkg::*;

  localparam int SLOTS        = TABLE_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 750;
  localparam int PHASE_LEN    = 60;   // items per burst / gappy phase
  localparam int TAIL_CYCLES  = 16;   // longer than the pipeline latency
  localparam int DRAIN_LIMIT  = 2000;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     start      = 1'b0;
  logic signed [ID_W-1:0]   in_flow_id = '0;
  logic                     busy;
  logic                     out_valid;
  logic        [SLOT_W-1:0] out_slot_first;
  logic        [SLOT_W-1:0] out_slot_second;
  logic        [SLOT_W-1:0] out_slot_third;

  int mismatches;
  int slots_pending;
  int results_checked;

  int directed_sent = 0;
  int random_sent   = 0;
  int drains        = 0;

  always #5 clk = ~clk;

  flow_triple_hash_index_core #(
    .TABLE_ENTRIES(SLOTS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_flow_id     (in_flow_id),
    .out_valid      (out_valid),
    .out_slot_first (out_slot_first),
    .out_slot_second(out_slot_second),
    .out_slot_third (out_slot_third)
  );

  flow_triple_hash_index_checker #(
    .TABLE_ENTRIES(SLOTS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .flow_id        (in_flow_id),
    .out_valid      (out_valid),
    .slot_first     (out_slot_first),
    .slot_second    (out_slot_second),
    .slot_third     (out_slot_third),
    .mismatches     (mismatches),
    .slots_pending  (slots_pending),
    .results_checked(results_checked)
  );

  // One transaction on the input channel. An idle gap drops start and puts
  // junk on the id bus so the DUT must ignore it. With no gap, start simply
  // stays high into the next transaction (one NBA per step on start).
  task automatic send_flow(input logic [ID_W-1:0] id, input int gap);
    if (gap > 0) begin
      start      <= 1'b0;
      in_flow_id <= $urandom();
      repeat (gap - 1) begin
        @(posedge clk);
        in_flow_id <= $urandom();
      end
      @(posedge clk);
    end
    start      <= 1'b1;
    in_flow_id <= id;
    // accepted at the first edge where busy is low
    do @(posedge clk); while (busy);
  endtask

  // Hold off the sender until every pending result has come back.
  task automatic drain_results;
    start <= 1'b0;
    do @(posedge clk); while (slots_pending != 0);
    drains++;
  endtask

  // Random flow ids, mostly shaped: small magnitudes around zero, the signed
  // extremes, runs of consecutive ids as real flows produce, single-bit
  // patterns and their complements, and plain 32-bit noise for the rest.
  logic [ID_W-1:0] next_seq_id;

  function automatic logic [ID_W-1:0] pick_flow_id();
    logic [ID_W-1:0] id;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: id = $urandom();
      4, 5:       id = $urandom_range(0, 256) - 128;
      6: begin
        if ($urandom_range(0, 1))
          id = 32'h8000_0000 + $urandom_range(0, 15);
        else
          id = 32'h7fff_ffff - $urandom_range(0, 15);
      end
      7, 8: begin
        if ($urandom_range(0, 15) == 0) next_seq_id = $urandom();
        next_seq_id = next_seq_id + 1;
        id = next_seq_id;
      end
      default: begin
        id = 32'h1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1)) id = ~id;
      end
    endcase
    return id;
  endfunction

  logic [ID_W-1:0] directed_ids[$] = '{
    32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff,
    32'h8000_0000, 32'h8000_0001, 32'h7fff_fffe, 32'hffff_fffe,
    32'h5555_5555, 32'haaaa_aaaa, 32'hffff_0000, 32'h0000_ffff,
    32'h0000_0002, 32'h0000_03e8, 32'h0000_03e7, 32'hffff_fc18,
    32'h4000_0000, 32'hc000_0000, 32'h0001_0000, 32'h1234_5678,
    32'hdead_beef
  };

  initial begin : stimulus
    int  gap;
    int  cycles;
    bit  burst;
    next_seq_id = $urandom();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: signed extremes, sign boundary, bit patterns, multiples of the
    // table size. Back to back for the first twelve, then with gaps on the rest.
    foreach (directed_ids[i]) begin
      send_flow(directed_ids[i], (i < 12) ? 0 : $urandom_range(0, 12));
      directed_sent++;
    end
    drain_results();

    // Random: alternate fully back-to-back phases with gappy ones so idle
    // cycles land on every pipeline stage; one drain pause mid-run.
    burst = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) burst = ~burst;
      if (n == RANDOM_ITEMS / 2) drain_results();
      gap = burst ? 0 : $urandom_range(0, 12);
      send_flow(pick_flow_id(), gap);
      random_sent++;
    end
    start <= 1'b0;

    // Wait for the pipeline to empty, then keep watching for
    // spurious strobes.
    cycles = 0;
    do begin
      @(posedge clk);
      cycles++;
    end while (slots_pending != 0 && cycles < DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (slots_pending != 0)
      $display("ERROR: %0d expected results never arrived", slots_pending);
    $display("Covered %0d directed and %0d random flow ids, %0d results checked,",
             directed_sent, random_sent, results_checked);
    $display("back-to-back bursts, idle gaps of 0..12 cycles and %0d full drains.",
             drains);
    if (mismatches == 0 && slots_pending == 0) begin
      $display("PASS flow_triple_hash_index_core");
    end else begin
      $display("FAIL flow_triple_hash_index_core");
    end
    $finish;
  end

  // Hang guard: ends the run with a failure if the stimulus never finishes.
  initial begin
    #2_000_000;
    $display("FAIL flow_triple_hash_index_core");
    $finish;
  end

endmodule
